### rtl/core/array_offset_index_converter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the array offset / index converter
// Shorthand for clocked properties checked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARRAY_OFFSET_INDEX_CONVERTER_UNIT_MACROS_SVH
`define ARRAY_OFFSET_INDEX_CONVERTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AOIC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AOIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/aoic_pkg.sv
// ----------------------------------------------------------------------------
// aoic_pkg
// Shared constants, types and helpers of the offset / index converter.
// ----------------------------------------------------------------------------
`default_nettype none

package aoic_pkg;

  localparam int MAX_DIMS       = 7;
  localparam int NUM_DIV        = MAX_DIMS - 1;
  localparam int OFF_W          = 32;
  localparam int DIM_W          = 16;
  localparam int RANK_W         = 3;
  localparam int REG_IDX_W      = 3;
  localparam int BITS_PER_STAGE = 4;
  localparam int STAGES_PER_DIM = OFF_W / BITS_PER_STAGE;
  localparam int DIV_STAGES     = NUM_DIV * STAGES_PER_DIM;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_RANK  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIM_0 = 3'd1;

  // Input kinds.
  localparam logic KIND_OFF_TO_IDX = 1'b0;
  localparam logic KIND_IDX_TO_OFF = 1'b1;

  typedef logic [MAX_DIMS-1:0][DIM_W-1:0] dims_t;
  typedef logic [NUM_DIV-1:0][DIM_W-1:0]  rems_t;

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic             kind;
    logic             flag;
    logic [OFF_W-1:0] num;
    logic [DIM_W-1:0] rem;
    rems_t            rems;
    dims_t            ix;
    logic [OFF_W-1:0] w;
    logic [OFF_W-1:0] prod;
    logic [OFF_W-1:0] acc;
  } pipe_t;

  // A dimension of size zero counts as one in the arithmetic.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    eff_dim = (d == '0) ? DIM_W'(1) : d;
  endfunction

  // Term (index - 1) * stride, modulo 2^32.
  function automatic logic [OFF_W-1:0] idx_term(input logic [DIM_W-1:0] ix,
                                                input logic [OFF_W-1:0] w);
    logic [OFF_W-1:0] ixm1;
    ixm1 = OFF_W'(ix) - OFF_W'(1);
    idx_term = ixm1 * w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/aoic_front.sv
// ----------------------------------------------------------------------------
// aoic_front
// Input register: captures a transfer, checks bounds and seeds the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module aoic_front import aoic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [RANK_W-1:0] rank,
  input  wire dims_t             dims,
  input  wire logic              in_valid,
  input  wire logic              kind,
  input  wire logic [OFF_W-1:0]  offset,
  input  wire dims_t             ix,
  output logic                   out_valid,
  output pipe_t                  out_data
);

  pipe_t seed;
  logic  empty;
  logic  bad;

  // Empty array and index bound checks over the dimensions in use.
  always_comb begin
    empty = 1'b0;
    bad   = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ({1'b0, rank} > 4'(d)) begin
        if (dims[d] == '0) empty = 1'b1;
        if (ix[d] == '0 || ix[d] > dims[d]) bad = 1'b1;
      end
    end
    seed      = '0;
    seed.kind = kind;
    seed.flag = empty || (kind == KIND_IDX_TO_OFF && bad);
    seed.num  = offset;
    seed.ix   = ix;
    seed.w    = OFF_W'(1);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= seed;
    end
  end

endmodule

`default_nettype wire

### rtl/core/aoic_div_stage.sv
// ----------------------------------------------------------------------------
// aoic_div_stage
// One stage of the mixed-radix divider: a few quotient bits of one dimension,
// plus one step of the stride/offset accumulation for the reverse direction.
// ----------------------------------------------------------------------------
`default_nettype none

module aoic_div_stage import aoic_pkg::*; #(
  parameter int SEG  = 0,
  parameter int STEP = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [RANK_W-1:0] rank,
  input  wire dims_t             dims,
  input  wire logic              in_valid,
  input  wire pipe_t             in_data,
  output logic                   out_valid,
  output pipe_t                  out_data
);

  pipe_t            nxt;
  logic [DIM_W-1:0] dsr;
  logic [DIM_W:0]   t;
  logic             qbit;
  logic             in_use;

  always_comb begin
    nxt    = in_data;
    in_use = {1'b0, rank} > 4'(SEG);
    // Only dimensions below the slowest one in use are divided out.
    dsr    = ({1'b0, rank} > 4'(SEG + 1)) ? eff_dim(dims[SEG]) : DIM_W'(1);

    // Restoring long division, one quotient bit per step.
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      t    = {nxt.rem, nxt.num[OFF_W-1]};
      qbit = (t >= {1'b0, dsr});
      if (qbit) begin
        nxt.rem = DIM_W'(t - {1'b0, dsr});
      end else begin
        nxt.rem = t[DIM_W-1:0];
      end
      nxt.num = {nxt.num[OFF_W-2:0], qbit};
    end

    // Remainder of this dimension is final at the last step.
    if (STEP == STAGES_PER_DIM - 1) begin
      nxt.rems[SEG] = nxt.rem;
      nxt.rem       = '0;
    end

    // Reverse direction: term, stride update, accumulate.
    if (STEP == 0) begin
      nxt.prod = in_use ? idx_term(in_data.ix[SEG], in_data.w) : '0;
    end
    if (STEP == 1) begin
      nxt.w = OFF_W'(in_data.w * {{(OFF_W-DIM_W){1'b0}}, eff_dim(dims[SEG])});
    end
    if (STEP == 2) begin
      nxt.acc = in_data.acc + in_data.prod;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/aoic_back.sv
// ----------------------------------------------------------------------------
// aoic_back
// Tail of the pipeline: slowest dimension term, result formatting, range
// flag and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aoic_back import aoic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [RANK_W-1:0] rank,
  input  wire dims_t             dims,
  input  wire logic              in_valid,
  input  wire pipe_t             in_data,
  output logic                   mid_valid,
  output logic                   out_valid,
  output logic [OFF_W-1:0]       offset_out,
  output dims_t                  index_out,
  output logic                   out_of_range
);

  pipe_t            mid;
  pipe_t            mid_next;
  logic [DIM_W-1:0] top_dim;
  logic [OFF_W-1:0] off_res;
  dims_t            idx_res;
  logic             flag_res;

  // Term of the slowest dimension.
  always_comb begin
    mid_next      = in_data;
    mid_next.prod = ({1'b0, rank} > 4'(MAX_DIMS - 1)) ?
                    idx_term(in_data.ix[MAX_DIMS-1], in_data.w) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (adv) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid <= mid_next;
    end
  end

  // Result formatting.
  always_comb begin
    top_dim  = (rank == '0) ? DIM_W'(1) : eff_dim(dims[RANK_W'(rank - RANK_W'(1))]);
    idx_res  = '0;
    off_res  = '0;
    flag_res = mid.flag;
    if (mid.kind == KIND_IDX_TO_OFF) begin
      off_res = mid.acc + mid.prod;
    end else begin
      if (mid.num >= {{(OFF_W-DIM_W){1'b0}}, top_dim}) flag_res = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
        if ({1'b0, rank} == 4'(d + 1)) begin
          idx_res[d] = mid.num[DIM_W-1:0] + DIM_W'(1);
        end else if (d < NUM_DIV && {1'b0, rank} > 4'(d + 1)) begin
          idx_res[d] = mid.rems[d] + DIM_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      offset_out   <= off_res;
      index_out    <= idx_res;
      out_of_range <= flag_res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/array_offset_index_converter_unit.sv
// ----------------------------------------------------------------------------
// array_offset_index_converter_unit
// Column-major offset <-> 1-based index converter, fully pipelined.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   input    | in_valid / in_stall | kind, offset, index_0..index_6
//   output   | out_valid/out_stall | offset_out, index_out_0..6, out_of_range
//   config   | wr_en               | wr_index, wr_data
//
// One transfer is accepted every cycle unless the output is stalled. There are 51
// register stages: the input register, the divider chain (six dimensions, 32
// quotient bits each, four bits a stage, 48 stages), the slowest-dimension term
// and the output register.
// Reset restores rank 1 and all sizes 1 and empties the pipeline.
// A stall on a valid output freezes every stage and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_offset_index_converter_unit_macros.svh"

module array_offset_index_converter_unit import aoic_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [DIM_W-1:0]     wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  input  wire logic [OFF_W-1:0]     offset,
  input  wire logic [DIM_W-1:0]     index_0,
  input  wire logic [DIM_W-1:0]     index_1,
  input  wire logic [DIM_W-1:0]     index_2,
  input  wire logic [DIM_W-1:0]     index_3,
  input  wire logic [DIM_W-1:0]     index_4,
  input  wire logic [DIM_W-1:0]     index_5,
  input  wire logic [DIM_W-1:0]     index_6,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OFF_W-1:0]          offset_out,
  output logic [DIM_W-1:0]          index_out_0,
  output logic [DIM_W-1:0]          index_out_1,
  output logic [DIM_W-1:0]          index_out_2,
  output logic [DIM_W-1:0]          index_out_3,
  output logic [DIM_W-1:0]          index_out_4,
  output logic [DIM_W-1:0]          index_out_5,
  output logic [DIM_W-1:0]          index_out_6,
  output logic                      out_of_range
);

  logic [RANK_W-1:0]     rank;
  dims_t                 dims;
  logic                  adv;
  dims_t                 ix_in;
  dims_t                 index_out;
  logic                  mid_valid;
  logic [DIV_STAGES:0]   chain_valid;
  pipe_t                 chain_data [DIV_STAGES+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_W'(1);
      for (int d = 0; d < MAX_DIMS; d++) dims[d] <= DIM_W'(1);
    end else if (wr_en) begin
      if (wr_index == REG_RANK) begin
        rank <= wr_data[RANK_W-1:0];
      end else begin
        dims[REG_IDX_W'(wr_index - REG_DIM_0)] <= wr_data;
      end
    end
  end

  // Global advance: the whole pipeline moves unless the result is held.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign ix_in = {index_6, index_5, index_4, index_3, index_2, index_1, index_0};

  aoic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .rank      (rank),
    .dims      (dims),
    .in_valid  (in_valid),
    .kind      (kind),
    .offset    (offset),
    .ix        (ix_in),
    .out_valid (chain_valid[0]),
    .out_data  (chain_data[0])
  );

  // Divider chain, one dimension per group of stages.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    aoic_div_stage #(
      .SEG  (g / STAGES_PER_DIM),
      .STEP (g % STAGES_PER_DIM)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .rank      (rank),
      .dims      (dims),
      .in_valid  (chain_valid[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  aoic_back u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .rank         (rank),
    .dims         (dims),
    .in_valid     (chain_valid[DIV_STAGES]),
    .in_data      (chain_data[DIV_STAGES]),
    .mid_valid    (mid_valid),
    .out_valid    (out_valid),
    .offset_out   (offset_out),
    .index_out    (index_out),
    .out_of_range (out_of_range)
  );

  assign index_out_0 = index_out[0];
  assign index_out_1 = index_out[1];
  assign index_out_2 = index_out[2];
  assign index_out_3 = index_out[3];
  assign index_out_4 = index_out[4];
  assign index_out_5 = index_out[5];
  assign index_out_6 = index_out[6];

  // Checks.
  `AOIC_ASSERT_NEXT(a_front_load, in_valid && !in_stall, chain_valid[0])
  `AOIC_ASSERT_NEXT(a_chain_hold, !adv, $stable(chain_valid))
  `AOIC_ASSERT_NEXT(a_tail_move, adv && chain_valid[DIV_STAGES], mid_valid)
  `AOIC_ASSERT_SAME(a_kind_excl, out_valid && offset_out != 0, index_out_0 == 0 && index_out_6 == 0)

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offset / index converter testbench
// Drives offset-to-index and index-to-offset conversions through the unit
// under several rank and size settings, predicts each result from the
// column-major arithmetic and compares every output transfer field by field.
// ----------------------------------------------------------------------------

import aoic_pkg::*;

typedef struct {
  logic [OFF_W-1:0] off;
  logic [DIM_W-1:0] ix [MAX_DIMS];
  logic             oor;
} conv_result_t;

// Holds the expected conversions and the array geometry they are based on.
class conversion_scoreboard;
  logic [2:0]       rank_q;
  logic [DIM_W-1:0] dim_q [MAX_DIMS];
  conv_result_t     pending [$];
  int               errors;

  function void reset_geometry();
    rank_q = 3'd1;
    foreach (dim_q[d]) dim_q[d] = 16'd1;
  endfunction

  function void write_reg(logic [2:0] idx, logic [DIM_W-1:0] val);
    if (idx == REG_RANK) rank_q = val[2:0];
    else dim_q[idx - REG_DIM_0] = val;
  endfunction

  // Predict the conversion of one accepted input transfer.
  function void note_input(logic k, logic [OFF_W-1:0] off_in, logic [DIM_W-1:0] ix_in [MAX_DIMS]);
    conv_result_t     res;
    longint unsigned  sat [MAX_DIMS];
    logic [OFF_W-1:0] wrap [MAX_DIMS];
    longint unsigned  s, rem, q, dv;
    logic [OFF_W-1:0] w, acc;
    bit               empty;
    int               r;
    s = 1; w = 1; empty = 0; acc = 0;
    r = (rank_q > MAX_DIMS) ? MAX_DIMS : rank_q;
    res.off = '0; res.oor = 0;
    foreach (res.ix[d]) res.ix[d] = '0;
    for (int d = 0; d < r; d++) begin
      dv = dim_q[d];
      sat[d] = s; wrap[d] = w;
      if (dv == 0) begin
        empty = 1; dv = 1;
      end
      s = s * dv;
      if (s > 64'h1_0000_0000) s = 64'h1_0000_0000;
      w = w * OFF_W'(dv);
    end
    if (k == KIND_OFF_TO_IDX) begin
      rem = off_in;
      if (off_in >= s) res.oor = 1;
      for (int d = r - 1; d >= 0; d--) begin
        q = rem / sat[d];
        rem = rem % sat[d];
        res.ix[d] = DIM_W'(q + 1);
      end
    end else begin
      for (int d = 0; d < r; d++) begin
        if (ix_in[d] == 0 || ix_in[d] > dim_q[d]) res.oor = 1;
        acc = acc + (OFF_W'(ix_in[d]) - 1) * wrap[d];
      end
      res.off = acc;
    end
    if (empty) res.oor = 1;
    pending.push_back(res);
  endfunction

  // Compare one output transfer with the oldest prediction.
  function void check_result(conv_result_t got);
    conv_result_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result offset %h", $time, got.off);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.off !== exp_r.off) begin
      $display("%0t: offset_out expected %h actual %h", $time, exp_r.off, got.off);
      errors++;
    end
    foreach (got.ix[d])
      if (got.ix[d] !== exp_r.ix[d]) begin
        $display("%0t: index_out_%0d expected %h actual %h", $time, d, exp_r.ix[d], got.ix[d]);
        errors++;
      end
    if (got.oor !== exp_r.oor) begin
      $display("%0t: out_of_range expected %b actual %b", $time, exp_r.oor, got.oor);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int LATENCY = 51;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [DIM_W-1:0] wr_data;
  logic in_valid, in_stall, kind;
  logic [OFF_W-1:0] offset;
  logic [DIM_W-1:0] index_0, index_1, index_2, index_3, index_4, index_5, index_6;
  logic out_valid, out_stall;
  logic [OFF_W-1:0] offset_out;
  logic [DIM_W-1:0] index_out_0, index_out_1, index_out_2, index_out_3;
  logic [DIM_W-1:0] index_out_4, index_out_5, index_out_6;
  logic out_of_range;

  conversion_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  longint cycles;

  array_offset_index_converter_unit uut (.*);

  // Clock.
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Cycle limit guards against a hung handshake.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("array_offset_index_converter_unit verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls and a check of every output transfer.
  always @(posedge clk) begin
    conv_result_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.off = offset_out;
        got.ix = '{index_out_0, index_out_1, index_out_2, index_out_3,
                   index_out_4, index_out_5, index_out_6};
        got.oor = out_of_range;
        sb.check_result(got);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Send one conversion; the prediction is noted at the accepting edge.
  task automatic send_item(logic k, logic [OFF_W-1:0] off_in, logic [DIM_W-1:0] ix [MAX_DIMS]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; kind <= k; offset <= off_in;
    {index_0, index_1, index_2, index_3, index_4, index_5, index_6}
      <= {ix[0], ix[1], ix[2], ix[3], ix[4], ix[5], ix[6]};
    do @(posedge clk); while (in_stall);
    sb.note_input(k, off_in, ix);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Random item: mostly in-range indices or offsets, sometimes anything.
  task automatic send_random();
    logic [DIM_W-1:0] ix [MAX_DIMS];
    logic [OFF_W-1:0] off_in;
    longint unsigned  cnt;
    logic k;
    k = $urandom_range(1);
    cnt = 1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < sb.rank_q) cnt = cnt * ((sb.dim_q[d] == 0) ? 1 : sb.dim_q[d]);
      if (cnt > 64'hFFFF_FFFF) cnt = 64'h1_0000_0000;
      if ($urandom_range(9) < 8 && sb.dim_q[d] != 0)
        ix[d] = $urandom_range(sb.dim_q[d], 1);
      else
        ix[d] = $urandom;
    end
    if ($urandom_range(9) < 8) off_in = $urandom_range(32'(cnt - 1), 0);
    else off_in = $urandom;
    send_item(k, off_in, ix);
  endtask

  task automatic set_geometry(logic [2:0] r, logic [DIM_W-1:0] d [MAX_DIMS]);
    drain();
    wr_en <= 1'b1; wr_index <= REG_RANK; wr_data <= DIM_W'(r);
    @(posedge clk);
    sb.write_reg(REG_RANK, DIM_W'(r));
    for (int i = 0; i < MAX_DIMS; i++) begin
      wr_index <= REG_DIM_0 + 3'(i); wr_data <= d[i];
      @(posedge clk);
      sb.write_reg(REG_DIM_0 + 3'(i), d[i]);
    end
    wr_en <= 1'b0;
  endtask

  initial begin
    logic [DIM_W-1:0] ix [MAX_DIMS];
    logic [DIM_W-1:0] dims [MAX_DIMS];
    sb = new();
    sb.reset_geometry();
    send_idle_pct = 19; recv_idle_pct = 51;
    rst <= 1'b1; wr_en <= 1'b0; wr_index <= '0; wr_data <= '0;
    in_valid <= 1'b0; kind <= 1'b0; offset <= '0;
    {index_0, index_1, index_2, index_3, index_4, index_5, index_6} <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset geometry (rank 1, size 1).
    foreach (ix[d]) ix[d] = 16'd1;
    send_item(KIND_OFF_TO_IDX, 32'd0, ix);
    send_item(KIND_OFF_TO_IDX, 32'd1, ix);
    send_item(KIND_IDX_TO_OFF, 32'd0, ix);

    // Full-size array: strides saturate and wrap.
    dims = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    set_geometry(3'd7, dims);
    send_item(KIND_OFF_TO_IDX, 32'hFFFF_FFFF, ix);
    send_item(KIND_OFF_TO_IDX, 32'h0, ix);
    foreach (ix[d]) ix[d] = 16'hFFFF;
    send_item(KIND_IDX_TO_OFF, 32'h0, ix);
    foreach (ix[d]) ix[d] = 16'h0;
    send_item(KIND_IDX_TO_OFF, 32'hFFFF_FFFF, ix);

    // Rank zero and a zero-sized dimension.
    dims = '{16'd3, 16'd0, 16'd5, 16'd1, 16'd2, 16'd7, 16'd9};
    set_geometry(3'd0, dims);
    send_item(KIND_OFF_TO_IDX, 32'd0, ix);
    send_item(KIND_OFF_TO_IDX, 32'd5, ix);
    send_item(KIND_IDX_TO_OFF, 32'd0, ix);
    set_geometry(3'd3, dims);
    ix = '{16'd2, 16'd1, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0};
    send_item(KIND_IDX_TO_OFF, 32'd0, ix);
    send_item(KIND_OFF_TO_IDX, 32'd7, ix);

    // Small cube: boundary indices and offsets.
    dims = '{16'd4, 16'd3, 16'd2, 16'd5, 16'd1, 16'd6, 16'd2};
    set_geometry(3'd7, dims);
    send_item(KIND_OFF_TO_IDX, 32'd1439, ix);
    send_item(KIND_OFF_TO_IDX, 32'd1440, ix);
    ix = '{16'd4, 16'd3, 16'd2, 16'd5, 16'd1, 16'd6, 16'd2};
    send_item(KIND_IDX_TO_OFF, 32'd0, ix);
    ix = '{16'd5, 16'd3, 16'd2, 16'd5, 16'd1, 16'd6, 16'd3};
    send_item(KIND_IDX_TO_OFF, 32'd0, ix);

    // Random phases over several geometries and idling patterns.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 51; recv_idle_pct = 19; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      foreach (dims[d])
        case ($urandom_range(3))
          0: dims[d] = $urandom_range(1, 0);
          1: dims[d] = 16'hFFFF;
          default: dims[d] = $urandom_range(40, 1);
        endcase
      set_geometry(3'($urandom_range(7)), dims);
      repeat (70) send_random();
    end
    drain();
    if (sb.errors == 0)
      $display("array_offset_index_converter_unit verification clean");
    else
      $display("array_offset_index_converter_unit verification failed");
    $finish;
  end
endmodule
